@@ hw/rtl/timeout_bank_led_blinker_assert.svh @@
// assertion macros for the timeout bank and led blinker
// used by the top level; takes the clock and the active-low reset as arguments
`ifndef TIMEOUT_BANK_LED_BLINKER_ASSERT_SVH
`define TIMEOUT_BANK_LED_BLINKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("timeout bank: same-cycle check failed");

// next-cycle implication, checked outside reset
`define TMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("timeout bank: next-cycle check failed");

`endif

@@ hw/rtl/tmb_pkg.sv @@
// shared types and constants for the timeout bank and led blinker
// no dependencies; used by every other rtl file except the assertion header
`default_nettype none

package tmb_pkg;

	localparam int unsigned NUM_TIMERS = 4;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned NUM_LEDS   = 4;
	localparam int unsigned LED_W      = 2 * NUM_LEDS;

	typedef logic [CNT_W-1:0] count_t;

	// item modes
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_LEDS   = 2'd3;

	// timer indexes
	localparam logic [1:0] TMR_DELAY = 2'd0;
	localparam logic [1:0] TMR_FAN   = 2'd1;
	localparam logic [1:0] TMR_BLINK = 2'd2;
	localparam logic [1:0] TMR_PDOWN = 2'd3;

	// requested colors
	localparam logic [1:0] COLOR_OFF    = 2'd0;
	localparam logic [1:0] COLOR_GREEN  = 2'd1;
	localparam logic [1:0] COLOR_YELLOW = 2'd2;
	localparam logic [1:0] COLOR_RED    = 2'd3;

	// active-low led pairs, low bit green
	localparam logic [1:0] PAIR_OFF       = 2'b11;
	localparam logic [1:0] FP_GREEN       = 2'b10;
	localparam logic [1:0] FP_YELLOW      = 2'b00;
	localparam logic [1:0] FP_RED         = 2'b01;
	localparam logic [1:0] FAN_GREEN      = 2'b10;
	localparam logic [1:0] FAN_YELLOW     = 2'b01;

	localparam logic [LED_W-1:0] FP_BITS    = 8'h03;
	localparam logic [LED_W-1:0] OTHER_BITS = 8'hFC;

	// reset values
	localparam count_t           BLINK_PERIOD_RST = 16'd1000;
	localparam logic [LED_W-1:0] LED_RST          = 8'hFF;
	localparam logic [1:0]       SAVED_RST        = PAIR_OFF;

	// decoded strobes for one item, only high when the item is processed
	typedef struct packed {
		logic tick;
		logic load;
		logic cancel;
		logic set_leds;
	} step_ctl_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] timer_select;
		count_t     load_value;
		logic [3:0] led_mask;
		logic [1:0] led_color;
		logic       blink_on;
	} item_t;

	typedef struct packed {
		logic [NUM_TIMERS-1:0] expired_flags;
		logic [LED_W-1:0]      led_register;
		logic                  led_write;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/tmb_ifs.sv @@
// handshake channels of the timeout bank: item input, result output, config write
// depends on tmb_pkg for field widths
`default_nettype none

interface tmb_req_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           mode;
	logic [1:0]           timer_select;
	tmb_pkg::count_t      load_value;
	logic [3:0]           led_mask;
	logic [1:0]           led_color;
	logic                 blink_on;

	modport source (output valid, mode, timer_select, load_value, led_mask,
		led_color, blink_on, input ready);
	modport sink (input valid, mode, timer_select, load_value, led_mask,
		led_color, blink_on, output ready);
endinterface

interface tmb_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tmb_pkg::NUM_TIMERS-1:0]  expired_flags;
	logic [tmb_pkg::LED_W-1:0]       led_register;
	logic                            led_write;

	modport source (output valid, expired_flags, led_register, led_write, input ready);
	modport sink (input valid, expired_flags, led_register, led_write, output ready);
endinterface

interface tmb_cfg_if;
	logic            valid;
	logic            ready;
	tmb_pkg::count_t data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/timeout_bank_led_blinker.sv @@
// top level of the timeout bank and led blinker
// depends on tmb_pkg, tmb_ifs, tmb_timers, tmb_leds and the assertion header
//
// Usage:
// req carries one item per handshake: tick, load timer, cancel timer or set
// leds. rsp returns exactly one result per item: the four expiry flags, the
// active-low led register and led_write. cfg writes blink_period (ticks
// between blink toggles); write it only while no item is in flight.
// Flow: an accepted item waits in the input register; once the output
// register is empty or being read, its result is taken into it and
// rsp.valid rises. Throughput: one item per cycle while rsp takes results;
// the whole timer and led update is one short step between those registers.
// When rsp stalls, the output register holds its result and the input
// register still takes one more item; req.ready drops only while both are
// full. Reset clears all timers and flags, turns all leds off, clears blink
// enables and sets blink_period to 1000; both registers come up empty.
`default_nettype none

`include "timeout_bank_led_blinker_assert.svh"

module timeout_bank_led_blinker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tmb_req_if.sink    req,
	tmb_rsp_if.source  rsp,
	tmb_cfg_if.sink    cfg
);

	tmb_pkg::item_t                 item_s1;
	logic                           valid_s1;
	tmb_pkg::result_t               res_q;
	logic                           rsp_valid_q;
	tmb_pkg::count_t                period_q;
	logic                           advance;
	tmb_pkg::step_ctl_t             step;
	logic                           blink_expire;
	logic                           any_blink;
	logic [tmb_pkg::NUM_TIMERS-1:0] expired_next;
	logic [tmb_pkg::LED_W-1:0]      led_next;

	// handshake control
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= tmb_pkg::BLINK_PERIOD_RST;
		end else if (cfg.valid && cfg.ready) begin
			period_q <= cfg.data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{mode: req.mode, timer_select: req.timer_select,
				load_value: req.load_value, led_mask: req.led_mask,
				led_color: req.led_color, blink_on: req.blink_on};
		end
	end

	// decode the held item, only when it moves on
	assign step.tick     = advance && (item_s1.mode == tmb_pkg::MODE_TICK);
	assign step.load     = advance && (item_s1.mode == tmb_pkg::MODE_LOAD);
	assign step.cancel   = advance && (item_s1.mode == tmb_pkg::MODE_CANCEL);
	assign step.set_leds = advance && (item_s1.mode == tmb_pkg::MODE_LEDS);

	tmb_timers u_timers (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.timer_select (item_s1.timer_select),
		.load_value   (item_s1.load_value),
		.period       (period_q),
		.any_blink    (any_blink),
		.blink_expire (blink_expire),
		.expired_next (expired_next)
	);

	tmb_leds u_leds (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.led_mask     (item_s1.led_mask),
		.led_color    (item_s1.led_color),
		.blink_on     (item_s1.blink_on),
		.blink_expire (blink_expire),
		.any_blink    (any_blink),
		.led_next     (led_next)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= '{expired_flags: expired_next, led_register: led_next,
				led_write: step.set_leds || blink_expire};
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.expired_flags = res_q.expired_flags;
	assign rsp.led_register  = res_q.led_register;
	assign rsp.led_write     = res_q.led_write;

	// checks
	`TMB_ASSERT_NOW(a_blink_flag_never_set, clk, arst_n, rsp.valid, !rsp.expired_flags[tmb_pkg::TMR_BLINK])
	`TMB_ASSERT_NEXT(a_held_item_kept, clk, arst_n, valid_s1 && !advance, valid_s1)
	`TMB_ASSERT_NEXT(a_no_write_on_timer_cmd, clk, arst_n, step.load || step.cancel, !res_q.led_write)

endmodule

`default_nettype wire

@@ hw/rtl/tmb_timers.sv @@
// bank of four countdown timers with expiry flags
// depends on tmb_pkg; driven by the top level, paired with tmb_leds
`default_nettype none

module tmb_timers (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tmb_pkg::step_ctl_t             step,
	input  wire logic [1:0]                     timer_select,
	input  wire tmb_pkg::count_t                load_value,
	input  wire tmb_pkg::count_t                period,
	input  wire logic                           any_blink,
	output      logic                           blink_expire,
	output      logic [tmb_pkg::NUM_TIMERS-1:0] expired_next
);

	tmb_pkg::count_t                cnt_q [tmb_pkg::NUM_TIMERS];
	tmb_pkg::count_t                cnt_d [tmb_pkg::NUM_TIMERS];
	logic [tmb_pkg::NUM_TIMERS-1:0] exp_q;
	logic [tmb_pkg::NUM_TIMERS-1:0] exp_d;

	// next timer state for the item being processed
	always_comb begin
		cnt_d        = cnt_q;
		exp_d        = exp_q;
		blink_expire = 1'b0;
		if (step.tick) begin
			for (int i = 0; i < tmb_pkg::NUM_TIMERS; i++) begin
				if (cnt_q[i] != '0) begin
					cnt_d[i] = cnt_q[i] - tmb_pkg::count_t'(1);
					if (cnt_q[i] == tmb_pkg::count_t'(1)) begin
						// blink timer reloads instead of flagging
						if (i == int'(tmb_pkg::TMR_BLINK)) begin
							blink_expire = 1'b1;
							cnt_d[i]     = period;
							exp_d[i]     = 1'b0;
						end else begin
							exp_d[i] = 1'b1;
						end
					end
				end
			end
		end
		if (step.load) begin
			cnt_d[timer_select] = load_value;
			exp_d[timer_select] = 1'b0;
		end
		if (step.cancel) begin
			cnt_d[timer_select] = '0;
			exp_d[timer_select] = 1'b0;
		end
		// set-leds restarts or stops the blink timer
		if (step.set_leds) begin
			cnt_d[tmb_pkg::TMR_BLINK] = any_blink ? period : '0;
			exp_d[tmb_pkg::TMR_BLINK] = 1'b0;
		end
	end

	assign expired_next = exp_d;

	// timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tmb_pkg::NUM_TIMERS; i++) begin
				cnt_q[i] <= '0;
			end
			exp_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			exp_q <= exp_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tmb_leds.sv @@
// led register with per-led blink enables and front panel saved color
// depends on tmb_pkg; takes the blink expiry strobe from tmb_timers
`default_nettype none

module tmb_leds (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tmb_pkg::step_ctl_t        step,
	input  wire logic [3:0]                led_mask,
	input  wire logic [1:0]                led_color,
	input  wire logic                      blink_on,
	input  wire logic                      blink_expire,
	output      logic                      any_blink,
	output      logic [tmb_pkg::LED_W-1:0] led_next
);

	logic [tmb_pkg::LED_W-1:0]    led_q;
	logic [tmb_pkg::LED_W-1:0]    led_d;
	logic [tmb_pkg::NUM_LEDS-1:0] en_q;
	logic [tmb_pkg::NUM_LEDS-1:0] en_d;
	logic [1:0]                   sav_q;
	logic [1:0]                   sav_d;
	logic                         turn_off;

	assign turn_off = (led_color == tmb_pkg::COLOR_OFF) && !blink_on;

	// blink enables after a set-leds item
	always_comb begin
		en_d = en_q;
		if (step.set_leds) begin
			for (int i = 0; i < tmb_pkg::NUM_LEDS; i++) begin
				if (led_mask[i]) begin
					en_d[i] = blink_on;
				end
			end
		end
	end

	assign any_blink = (en_d != '0);

	// led bits and saved front panel color
	always_comb begin
		led_d = led_q;
		sav_d = sav_q;
		if (step.set_leds) begin
			// front panel, three colors
			if (led_mask[0]) begin
				if (turn_off) begin
					led_d[1:0] = tmb_pkg::PAIR_OFF;
				end else begin
					case (led_color)
						tmb_pkg::COLOR_GREEN:  led_d[1:0] = tmb_pkg::FP_GREEN;
						tmb_pkg::COLOR_YELLOW: led_d[1:0] = tmb_pkg::FP_YELLOW;
						tmb_pkg::COLOR_RED:    led_d[1:0] = tmb_pkg::FP_RED;
						default:               led_d[1:0] = led_q[1:0];
					endcase
				end
				sav_d = led_d[1:0];
			end
			// fan leds, red leaves them alone
			for (int i = 1; i < tmb_pkg::NUM_LEDS; i++) begin
				if (led_mask[i]) begin
					if (turn_off) begin
						led_d[2*i +: 2] = tmb_pkg::PAIR_OFF;
					end else begin
						case (led_color)
							tmb_pkg::COLOR_GREEN:  led_d[2*i +: 2] = tmb_pkg::FAN_GREEN;
							tmb_pkg::COLOR_YELLOW: led_d[2*i +: 2] = tmb_pkg::FAN_YELLOW;
							default:               led_d[2*i +: 2] = led_q[2*i +: 2];
						endcase
					end
				end
			end
		end
		// blink toggle on blink timer expiry
		if (blink_expire) begin
			if (en_q[0]) begin
				if ((led_q & tmb_pkg::FP_BITS) == {6'd0, sav_q}) begin
					led_d = led_q | tmb_pkg::FP_BITS;
				end else begin
					led_d = (led_q & tmb_pkg::OTHER_BITS) | {6'd0, sav_q};
				end
			end
			for (int i = 1; i < tmb_pkg::NUM_LEDS; i++) begin
				if (en_q[i]) begin
					led_d[2*i]     = 1'b1;
					led_d[2*i + 1] = ~led_q[2*i + 1];
				end
			end
		end
	end

	assign led_next = led_d;

	// led state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= tmb_pkg::LED_RST;
			en_q  <= '0;
			sav_q <= tmb_pkg::SAVED_RST;
		end else begin
			led_q <= led_d;
			en_q  <= en_d;
			sav_q <= sav_d;
		end
	end

endmodule

`default_nettype wire

@@ dv/timeout_bank_led_blinker_test.sv @@
// self-checking testbench for the timeout bank and led blinker
// depends on tmb_pkg, tmb_ifs and the timeout_bank_led_blinker rtl; a shadow model
// of the timers and led register predicts every result, checked as it comes back
`default_nettype none

module timeout_bank_led_blinker_test;
	import tmb_pkg::*;

	localparam int unsigned CYCLE_LIMIT       = 200000;
	localparam int unsigned POST_DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	tmb_req_if req_if();
	tmb_rsp_if rsp_if();
	tmb_cfg_if cfg_if();

	timeout_bank_led_blinker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// stimulus and expectations
	item_t       pending_items[$];
	result_t     expected_status[$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned items_sent;
	int unsigned error_count;
	int unsigned cycle_count;
	logic        item_taken;
	logic        hold_for_drain;

	// shadow copy of the block state
	count_t      shadow_count [NUM_TIMERS];
	logic [3:0]  shadow_flags;
	logic [7:0]  shadow_leds;
	logic [3:0]  shadow_blink_en;
	logic [1:0]  shadow_saved;
	count_t      shadow_period;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_error(string msg);
		$display("error at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// advance the shadow state by one item and return the status it produces
	function automatic result_t next_status(item_t it);
		result_t res;
		logic    lit_off;
		int      i;
		res.led_write = 1'b0;
		case (it.mode)
		MODE_TICK: begin
			for (i = 0; i < NUM_TIMERS; i++) begin
				if (shadow_count[i] != '0) begin
					shadow_count[i] = shadow_count[i] - 1'b1;
					if (shadow_count[i] == '0) begin
						if (i != TMR_BLINK) begin
							shadow_flags[i] = 1'b1;
						end else begin
							// front panel swaps between saved color and off
							if (shadow_blink_en[0]) begin
								if (shadow_leds[1:0] == shadow_saved)
									shadow_leds = shadow_leds | FP_BITS;
								else
									shadow_leds = (shadow_leds & OTHER_BITS) |
										{6'd0, shadow_saved};
							end
							// fan leds: green off, yellow flips
							for (int j = 1; j < NUM_LEDS; j++) begin
								if (shadow_blink_en[j]) begin
									shadow_leds[2*j]   = 1'b1;
									shadow_leds[2*j+1] = ~shadow_leds[2*j+1];
								end
							end
							res.led_write = 1'b1;
							shadow_count[TMR_BLINK] = shadow_period;
							shadow_flags[TMR_BLINK] = 1'b0;
						end
					end
				end
			end
		end
		MODE_LOAD: begin
			shadow_count[it.timer_select] = it.load_value;
			shadow_flags[it.timer_select] = 1'b0;
		end
		MODE_CANCEL: begin
			shadow_count[it.timer_select] = '0;
			shadow_flags[it.timer_select] = 1'b0;
		end
		default: begin
			// off without blink clears; off with blink keeps color bits
			lit_off = (it.led_color == COLOR_OFF) && !it.blink_on;
			if (it.led_mask[0]) begin
				if (lit_off) begin
					shadow_leds[1:0] = PAIR_OFF;
				end else begin
					case (it.led_color)
					COLOR_GREEN:  shadow_leds[1:0] = FP_GREEN;
					COLOR_YELLOW: shadow_leds[1:0] = FP_YELLOW;
					COLOR_RED:    shadow_leds[1:0] = FP_RED;
					default:      ;
					endcase
				end
				shadow_saved       = shadow_leds[1:0];
				shadow_blink_en[0] = it.blink_on;
			end
			// fan leds ignore red
			for (i = 1; i < NUM_LEDS; i++) begin
				if (it.led_mask[i]) begin
					if (lit_off)
						shadow_leds[2*i +: 2] = PAIR_OFF;
					else if (it.led_color == COLOR_GREEN)
						shadow_leds[2*i +: 2] = FAN_GREEN;
					else if (it.led_color == COLOR_YELLOW)
						shadow_leds[2*i +: 2] = FAN_YELLOW;
					shadow_blink_en[i] = it.blink_on;
				end
			end
			shadow_count[TMR_BLINK] = (shadow_blink_en != '0) ? shadow_period : '0;
			shadow_flags[TMR_BLINK] = 1'b0;
			res.led_write = 1'b1;
		end
		endcase
		res.expired_flags = shadow_flags;
		res.led_register  = shadow_leds;
		return res;
	endfunction

	// driver: items from the pending queue, random gaps, random result stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (!(req_if.valid && !item_taken)) begin
				if (hold_for_drain && expected_status.size() == 0)
					hold_for_drain = 1'b0;
				if (!hold_for_drain && pending_items.size() != 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					req_if.valid        <= 1'b1;
					req_if.mode         <= pending_items[0].mode;
					req_if.timer_select <= pending_items[0].timer_select;
					req_if.load_value   <= pending_items[0].load_value;
					req_if.led_mask     <= pending_items[0].led_mask;
					req_if.led_color    <= pending_items[0].led_color;
					req_if.blink_on     <= pending_items[0].blink_on;
					items_sent++;
					// now and then let everything drain before the next item
					if (items_sent % 64 == 0 || $urandom_range(79) == 0)
						hold_for_drain = 1'b1;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check results, then predict for newly accepted items
	always @(posedge clk) begin : monitor
		item_t   seen;
		result_t want;
		item_taken <= arst_n && req_if.valid && req_if.ready;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_status.size() == 0) begin
					report_error("result with no item outstanding");
				end else begin
					want = expected_status.pop_front();
					if (rsp_if.expired_flags !== want.expired_flags)
						report_error($sformatf("expired_flags got %h expected %h",
							rsp_if.expired_flags, want.expired_flags));
					if (rsp_if.led_register !== want.led_register)
						report_error($sformatf("led_register got %h expected %h",
							rsp_if.led_register, want.led_register));
					if (rsp_if.led_write !== want.led_write)
						report_error($sformatf("led_write got %b expected %b",
							rsp_if.led_write, want.led_write));
				end
			end
			if (req_if.valid && req_if.ready) begin
				seen.mode         = req_if.mode;
				seen.timer_select = req_if.timer_select;
				seen.load_value   = req_if.load_value;
				seen.led_mask     = req_if.led_mask;
				seen.led_color    = req_if.led_color;
				seen.blink_on     = req_if.blink_on;
				expected_status.push_back(next_status(seen));
				void'(pending_items.pop_front());
			end
			if (cfg_if.valid && cfg_if.ready)
				shadow_period = cfg_if.data;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout_bank_led_blinker_test failed");
			$finish;
		end
	end

	task automatic push_item(logic [1:0] mode, logic [1:0] sel, count_t value,
			logic [3:0] mask, logic [1:0] color, logic blink);
		item_t it;
		it.mode         = mode;
		it.timer_select = sel;
		it.load_value   = value;
		it.led_mask     = mask;
		it.led_color    = color;
		it.blink_on     = blink;
		pending_items.push_back(it);
	endtask

	function automatic item_t random_item(bit tick_only);
		item_t       it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (tick_only || pick < 40)
			it.mode = MODE_TICK;
		else if (pick < 65)
			it.mode = MODE_LOAD;
		else if (pick < 77)
			it.mode = MODE_CANCEL;
		else
			it.mode = MODE_LEDS;
		// mostly short counts so timers run out often
		pick = $urandom_range(9);
		if (pick < 6)
			it.load_value = count_t'($urandom_range(24));
		else if (pick < 9)
			it.load_value = count_t'($urandom_range(400));
		else
			it.load_value = count_t'($urandom_range(65535));
		it.timer_select = 2'($urandom_range(3));
		it.led_mask     = 4'($urandom_range(15));
		it.led_color    = 2'($urandom_range(3));
		it.blink_on     = 1'($urandom_range(1));
		return it;
	endfunction

	// random mix with bursts of ticks so blink toggles and expiries happen
	task automatic queue_random(int unsigned count);
		int unsigned n;
		int unsigned burst;
		n = 0;
		while (n < count) begin
			if ($urandom_range(3) == 0) begin
				burst = $urandom_range(1, 16);
				repeat (burst) pending_items.push_back(random_item(1'b1));
				n += burst;
			end else begin
				pending_items.push_back(random_item(1'b0));
				n++;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_blink_period(count_t value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_random_phase(count_t period, int unsigned send_pct,
			int unsigned recv_pct, int unsigned count);
		wait_idle();
		write_blink_period(period);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queue_random(count);
		wait_idle();
	endtask

	// main sequence
	initial begin
		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.mode         = MODE_TICK;
		req_if.timer_select = TMR_DELAY;
		req_if.load_value   = '0;
		req_if.led_mask     = '0;
		req_if.led_color    = COLOR_OFF;
		req_if.blink_on     = 1'b0;
		rsp_if.ready        = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.data         = '0;
		item_taken          = 1'b0;
		hold_for_drain      = 1'b0;
		items_sent          = 0;
		error_count         = 0;
		cycle_count         = 0;
		send_idle_pct       = 23;
		recv_idle_pct       = 87;
		for (int i = 0; i < NUM_TIMERS; i++) shadow_count[i] = '0;
		shadow_flags    = '0;
		shadow_leds     = LED_RST;
		shadow_blink_en = '0;
		shadow_saved    = SAVED_RST;
		shadow_period   = BLINK_PERIOD_RST;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: short blink period so toggles show up quickly
		write_blink_period(count_t'(2));
		push_item(MODE_TICK,   TMR_DELAY, '0,      4'h0, COLOR_OFF,    1'b0);
		// delay timer runs out, then a zero load leaves it idle
		push_item(MODE_LOAD,   TMR_DELAY, 16'd1,   4'h0, COLOR_OFF,    1'b0);
		push_item(MODE_TICK,   TMR_DELAY, '0,      4'hF, COLOR_RED,    1'b1);
		push_item(MODE_LOAD,   TMR_DELAY, '0,      4'h0, COLOR_OFF,    1'b0);
		push_item(MODE_LOAD,   TMR_FAN,   16'hFFFF, 4'h0, COLOR_OFF,   1'b0);
		push_item(MODE_LOAD,   TMR_PDOWN, 16'd3,   4'h0, COLOR_OFF,    1'b0);
		repeat (3) push_item(MODE_TICK, TMR_DELAY, '0, 4'h0, COLOR_OFF, 1'b0);
		// cancel of power-down zeroes its own timer
		push_item(MODE_CANCEL, TMR_PDOWN, 16'hFFFF, 4'h0, COLOR_OFF,   1'b0);
		push_item(MODE_CANCEL, TMR_FAN,   '0,      4'h0, COLOR_OFF,    1'b0);
		// blink timer expiry with nothing blinking still writes and reloads
		push_item(MODE_LOAD,   TMR_BLINK, 16'd1,   4'h0, COLOR_OFF,    1'b0);
		push_item(MODE_TICK,   TMR_DELAY, '0,      4'h0, COLOR_OFF,    1'b0);
		// empty mask still writes the led register
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'h0, COLOR_OFF,    1'b0);
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'hF, COLOR_GREEN,  1'b0);
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'h1, COLOR_YELLOW, 1'b0);
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'h1, COLOR_RED,    1'b1);
		// red on fan leds keeps their bits but sets blink
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'hE, COLOR_RED,    1'b1);
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'h2, COLOR_YELLOW, 1'b1);
		// off with blink keeps the color bits
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'h4, COLOR_OFF,    1'b1);
		repeat (4) push_item(MODE_TICK, TMR_DELAY, '0, 4'h0, COLOR_OFF, 1'b0);
		push_item(MODE_LEDS,   TMR_DELAY, '0,      4'hF, COLOR_OFF,    1'b0);
		push_item(MODE_LOAD,   TMR_DELAY, 16'hFFFF, 4'h0, COLOR_OFF,   1'b0);
		push_item(MODE_CANCEL, TMR_DELAY, '0,      4'h0, COLOR_OFF,    1'b0);

		// random phases over several blink periods, extremes included
		run_random_phase(count_t'(1),     23, 87, 100);
		run_random_phase(count_t'(65535), 87, 23, 60);
		run_random_phase(count_t'(3),     87, 23, 120);
		run_random_phase(count_t'(7),     0,  0,  120);

		repeat (POST_DRAIN_CYCLES) @(posedge clk);
		if (expected_status.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_status.size()));
		if (error_count == 0)
			$display("timeout_bank_led_blinker_test passed");
		else
			$display("timeout_bank_led_blinker_test failed");
		$finish;
	end

endmodule

`default_nettype wire
